/* design/pal_pkg.sv */
// shared codes and field widths for the positional array list
package pal_pkg;

  // field widths
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 8;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  // capacity in use after reset
  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 8'd128;

endpackage

/* design/positional_array_list_core.sv */
// Ordered list of signed 32-bit values kept in a CAPACITY-entry memory with a live count.
// Each input beat is one operation (insert at a 1-based position, delete at a 1-based
// position, or search for a value) and gives exactly one result beat. All work goes
// through the memory's one write port and one registered read port, walking one entry per
// cycle. An insert walks from the end of the list down to its position and a delete from
// its position to the end (an append only writes the new value), a search walks until its
// first match or the end of the list, and a rejected or unused operation goes straight to
// its result. The input is ready again once the result is registered, and is not ready
// while an operation is in progress; a finished result waits in an output register, and a
// further finished result holds the sequencer until that register is free. max_entries is
// written through cfg_wr_en / cfg_wr_data; the user must do so only while the block is
// idle, as the block itself does not enforce this. Values above CAPACITY act as CAPACITY.
// No clearing pass is needed after reset: only entries below the count are read.
module positional_array_list_core
  import pal_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [CFG_W-1:0]           cfg_wr_data,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_opcode,
  input  logic [POS_W-1:0]           in_position,
  input  logic signed [DATA_W-1:0]   in_item_value,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic [POS_W-1:0]           out_found_position,
  output logic signed [DATA_W-1:0]   out_removed_value,
  output logic [POS_W-1:0]           out_entry_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > POS_W) ? CW : POS_W;
  localparam int PW = LW + 1;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_DEL  = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]               state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [CFG_W-1:0]         max_entries_r;
  logic [AW-1:0]            ptr_r, ptr_nxt;
  logic [AW-1:0]            end_r, end_nxt;
  logic [AW-1:0]            wa_r, wa_nxt;
  logic                     more_r, more_nxt;
  logic                     rd_vld_r, rd_vld_nxt;
  logic                     first_r, first_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic [STATUS_W-1:0]      res_status_r, res_status_nxt;
  logic [POS_W-1:0]         res_found_r, res_found_nxt;
  logic signed [DATA_W-1:0] res_removed_r, res_removed_nxt;

  logic                     out_valid_r;
  logic [STATUS_W-1:0]      out_status_r;
  logic [POS_W-1:0]         out_found_r;
  logic signed [DATA_W-1:0] out_removed_r;
  logic [POS_W-1:0]         out_count_r;

  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rdata_r;
  logic                     mem_we;
  logic [AW-1:0]            mem_wa;
  logic signed [DATA_W-1:0] mem_wd;

  logic                     in_beat;
  logic                     out_slot_free;
  logic                     list_full;
  logic                     ins_bad_pos;
  logic                     del_bad_pos;

  assign in_ready      = (state_r == S_IDLE);
  assign in_beat       = in_valid && in_ready;
  assign out_slot_free = !out_valid_r || out_ready;

  // full when the count reaches the capacity in use
  assign list_full   = (count_r >= CW'(CAPACITY)) ||
                       (LW'(count_r) >= LW'(max_entries_r));
  assign ins_bad_pos = (in_position == '0) ||
                       (PW'(in_position) > (PW'(count_r) + PW'(1)));
  assign del_bad_pos = (in_position == '0) || (LW'(in_position) > LW'(count_r));

  // sequencer and walk pointer
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    ptr_nxt         = ptr_r;
    end_nxt         = end_r;
    wa_nxt          = wa_r;
    more_nxt        = more_r;
    rd_vld_nxt      = 1'b0;
    first_nxt       = first_r;
    val_nxt         = val_r;
    res_status_nxt  = res_status_r;
    res_found_nxt   = res_found_r;
    res_removed_nxt = res_removed_r;
    mem_we          = 1'b0;
    mem_wa          = wa_r;
    mem_wd          = rdata_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          val_nxt         = in_item_value;
          res_status_nxt  = ST_OK;
          res_found_nxt   = '0;
          res_removed_nxt = '0;
          state_nxt       = S_FIN;
          unique case (in_opcode)
            OP_INSERT: begin
              if (list_full) begin
                res_status_nxt = ST_FULL;
              end else if (ins_bad_pos) begin
                res_status_nxt = ST_BADPOS;
              end else begin
                // shift entries pos-1 .. count-1 up, top first
                ptr_nxt   = AW'(count_r - CW'(1));
                end_nxt   = AW'(in_position - POS_W'(1));
                more_nxt  = (PW'(in_position) != (PW'(count_r) + PW'(1)));
                state_nxt = S_INS;
              end
            end
            OP_DELETE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else if (del_bad_pos) begin
                res_status_nxt = ST_BADPOS;
              end else begin
                // first read is the removed entry, the rest shift down
                ptr_nxt   = AW'(in_position - POS_W'(1));
                end_nxt   = AW'(count_r - CW'(1));
                more_nxt  = 1'b1;
                first_nxt = 1'b1;
                state_nxt = S_DEL;
              end
            end
            OP_SEARCH: begin
              res_status_nxt = ST_NOTFOUND;
              if (count_r != '0) begin
                ptr_nxt   = '0;
                end_nxt   = AW'(count_r - CW'(1));
                more_nxt  = 1'b1;
                state_nxt = S_SRCH;
              end
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end

      S_INS: begin
        if (rd_vld_r) begin
          mem_we = 1'b1;
          mem_wa = wa_r;
          mem_wd = rdata_r;
        end else if (!more_r) begin
          mem_we    = 1'b1;
          mem_wa    = end_r;
          mem_wd    = val_r;
          count_nxt = count_r + CW'(1);
          state_nxt = S_FIN;
        end
        if (more_r) begin
          rd_vld_nxt = 1'b1;
          wa_nxt     = ptr_r + AW'(1);
          if (ptr_r == end_r) begin
            more_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r - AW'(1);
          end
        end
      end

      S_DEL: begin
        if (rd_vld_r) begin
          if (first_r) begin
            res_removed_nxt = rdata_r;
            first_nxt       = 1'b0;
          end else begin
            mem_we = 1'b1;
            mem_wa = wa_r;
            mem_wd = rdata_r;
          end
        end else if (!more_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_FIN;
        end
        if (more_r) begin
          rd_vld_nxt = 1'b1;
          wa_nxt     = ptr_r - AW'(1);
          if (ptr_r == end_r) begin
            more_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r + AW'(1);
          end
        end
      end

      S_SRCH: begin
        if (rd_vld_r && (rdata_r == val_r)) begin
          res_status_nxt = ST_OK;
          res_found_nxt  = POS_W'(wa_r) + POS_W'(1);
          state_nxt      = S_FIN;
        end else if (!rd_vld_r && !more_r) begin
          state_nxt = S_FIN;
        end
        if (more_r) begin
          rd_vld_nxt = 1'b1;
          wa_nxt     = ptr_r;
          if (ptr_r == end_r) begin
            more_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r + AW'(1);
          end
        end
      end

      S_FIN: begin
        if (out_slot_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      max_entries_r <= MAX_ENTRIES_RST;
      more_r        <= 1'b0;
      rd_vld_r      <= 1'b0;
      first_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      more_r   <= more_nxt;
      rd_vld_r <= rd_vld_nxt;
      first_r  <= first_nxt;
      if (cfg_wr_en) begin
        max_entries_r <= cfg_wr_data;
      end
      if (state_r == S_FIN && out_slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ptr_r         <= ptr_nxt;
    end_r         <= end_nxt;
    wa_r          <= wa_nxt;
    val_r         <= val_nxt;
    res_status_r  <= res_status_nxt;
    res_found_r   <= res_found_nxt;
    res_removed_r <= res_removed_nxt;
    if (state_r == S_FIN && out_slot_free) begin
      out_status_r  <= res_status_r;
      out_found_r   <= res_found_r;
      out_removed_r <= res_removed_r;
      out_count_r   <= POS_W'(count_r);
    end
  end

  // list storage: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[ptr_r];
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_found_r;
  assign out_removed_value  = out_removed_r;
  assign out_entry_count    = out_count_r;

  // count never passes the store size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("list count exceeds capacity");

  // count moves by at most one entry per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == $past(count_r)) ||
             (count_r == $past(count_r) + CW'(1)) ||
             (count_r == $past(count_r) - CW'(1)))
    else $error("list count jumped");

  // storage is untouched while idle or handing off a result
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_FIN) |-> !mem_we)
    else $error("memory written outside an operation");

  // an accepted beat always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (state_r != S_IDLE))
    else $error("accepted beat did not start an operation");

  // a found position lies within the list reported with it
  a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r != '0) |-> (out_found_r <= out_count_r))
    else $error("found position beyond list");

endmodule
